@@ rtl/si_pkg.sv @@
`default_nettype none

package si_pkg;

    localparam int FRAC_BITS = 8;

    // coordinate, difference, product and cross product widths
    localparam int CO_W   = 16;
    localparam int DIF_W  = CO_W + 1;
    localparam int PRD_W  = 2 * DIF_W;
    localparam int XP_W   = PRD_W + 1;
    localparam int P_W    = XP_W + DIF_W;
    localparam int A_W    = P_W + FRAC_BITS;
    localparam int Q_W    = CO_W + FRAC_BITS;
    localparam int M_W    = Q_W + 3;
    localparam int OUT_W  = 24;
    localparam int KIND_W = 3;
    localparam int DIV_STAGES = Q_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE   = 3'd0,
        KIND_CROSS  = 3'd1,
        KIND_START2 = 3'd2,
        KIND_END2   = 3'd3,
        KIND_START1 = 3'd4,
        KIND_END1   = 3'd5
    } t_kind;

    typedef struct packed {
        logic signed [CO_W-1:0] s1x;
        logic signed [CO_W-1:0] s1y;
        logic signed [CO_W-1:0] e1x;
        logic signed [CO_W-1:0] e1y;
        logic signed [CO_W-1:0] s2x;
        logic signed [CO_W-1:0] s2y;
        logic signed [CO_W-1:0] e2x;
        logic signed [CO_W-1:0] e2y;
    } t_seg;

    // item state through the divider
    typedef struct packed {
        t_kind                   kind;
        logic signed [OUT_W-1:0] ex;
        logic signed [OUT_W-1:0] ey;
        logic signed [CO_W-1:0]  ax;
        logic signed [CO_W-1:0]  ay;
        logic                    negx;
        logic                    negy;
        logic [XP_W-1:0]         dmag;
        logic [XP_W-1:0]         remx;
        logic [XP_W-1:0]         remy;
        logic [Q_W-1:0]          lowx;
        logic [Q_W-1:0]          lowy;
        logic [Q_W-1:0]          qx;
        logic [Q_W-1:0]          qy;
    } t_div;

    typedef struct packed {
        logic                    hit;
        logic [KIND_W-1:0]       hit_kind;
        logic signed [OUT_W-1:0] cross_x;
        logic signed [OUT_W-1:0] cross_y;
    } t_res;

    function automatic logic [OUT_W-1:0] to_fixed(input logic signed [CO_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v) <<< FRAC_BITS;
        return w[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] wrap_out(input logic signed [M_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/si_if.sv @@
`default_nettype none

interface si_in_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] seg1_start_x;
    logic signed [15:0] seg1_start_y;
    logic signed [15:0] seg1_end_x;
    logic signed [15:0] seg1_end_y;
    logic signed [15:0] seg2_start_x;
    logic signed [15:0] seg2_start_y;
    logic signed [15:0] seg2_end_x;
    logic signed [15:0] seg2_end_y;

    modport source (
        output valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
               seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y,
        input  ready
    );
    modport sink (
        input  valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
               seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y,
        output ready
    );
endinterface

interface si_out_if;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [2:0]        hit_kind;
    logic signed [23:0] cross_x;
    logic signed [23:0] cross_y;

    modport source (output valid, hit, hit_kind, cross_x, cross_y, input ready);
    modport sink (input valid, hit, hit_kind, cross_x, cross_y, output ready);
endinterface

`default_nettype wire

@@ rtl/segment_intersection.sv @@
`default_nettype none

// segment intersection pipeline: each transfer on i_seg carries two segments with signed
// 16-bit endpoints, and one transfer on o_res comes back for each, in order. a
// crossing (hit_kind 1) returns start1 + t * (end1 - start1) with 8 fraction bits, rounded
// to nearest with ties away from zero; otherwise the first of start2, end2, start1, end1
// that is collinear with and inside the other segment's bounding box is returned
// (hit_kind 2 to 5), else hit_kind 0 with zero coordinates. a new pair is taken every
// cycle while i_seg.ready is high. there are 5 geometry stages (differences, 17x17 products,
// cross products and classification, numerator products, magnitudes), 24 restoring divider
// stages giving one quotient bit each, 2 rounding stages and the output register.
// i_seg.ready is registered and drops only when the output skid stage is full.

module segment_intersection
    import si_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    si_in_if.sink     i_seg,
    si_out_if.source  o_res
);

    logic ce;
    t_seg seg;
    logic div_v [DIV_STAGES+1];
    t_div div_d [DIV_STAGES+1];
    logic rnd_v;
    t_res rnd_res;

    // whole pipeline advances while the skid stage has room
    assign i_seg.ready = ce;

    assign seg.s1x = i_seg.seg1_start_x;
    assign seg.s1y = i_seg.seg1_start_y;
    assign seg.e1x = i_seg.seg1_end_x;
    assign seg.e1y = i_seg.seg1_end_y;
    assign seg.s2x = i_seg.seg2_start_x;
    assign seg.s2y = i_seg.seg2_start_y;
    assign seg.e2x = i_seg.seg2_end_x;
    assign seg.e2y = i_seg.seg2_end_y;

    // orientation signs, classification and divider set-up
    si_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_seg.valid),
        .i_seg   (seg),
        .o_valid (div_v[0]),
        .o_d     (div_d[0])
    );

    // long division of the scaled offset by |den|, msb first
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        si_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_valid (div_v[g]),
            .i_d     (div_d[g]),
            .o_valid (div_v[g+1]),
            .o_d     (div_d[g+1])
        );
    end

    // add start point, round, select result
    si_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (div_v[DIV_STAGES]),
        .i_d     (div_d[DIV_STAGES]),
        .o_valid (rnd_v),
        .o_res   (rnd_res)
    );

    // output register plus skid entry
    si_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rnd_v),
        .i_res   (rnd_res),
        .o_ready (ce),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

@@ rtl/si_geom.sv @@
`default_nettype none

module si_geom
    import si_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_ce,
    input  wire logic i_valid,
    input  wire t_seg i_seg,
    output logic      o_valid,
    output t_div      o_d
);

    function automatic logic in_box(
        input logic signed [CO_W-1:0] ax, input logic signed [CO_W-1:0] ay,
        input logic signed [CO_W-1:0] bx, input logic signed [CO_W-1:0] by,
        input logic signed [CO_W-1:0] px, input logic signed [CO_W-1:0] py
    );
        logic okx, oky;
        okx = (px >= ax && px <= bx) || (px >= bx && px <= ax);
        oky = (py >= ay && py <= by) || (py >= by && py <= ay);
        return okx && oky;
    endfunction

    logic [4:0] r_v;

    // stage 1: differences and bounding box tests
    t_seg                    r1_s;
    logic signed [DIF_W-1:0] r1_dif [14];
    logic [3:0]              r1_box;

    // stage 2: products
    t_seg                    r2_s;
    logic signed [DIF_W-1:0] r2_d1x, r2_d1y;
    logic signed [PRD_W-1:0] r2_p [12];
    logic [3:0]              r2_box;

    // stage 3: orientations, classification
    t_kind                   r3_kind;
    logic signed [OUT_W-1:0] r3_ex, r3_ey;
    logic signed [CO_W-1:0]  r3_ax, r3_ay;
    logic signed [XP_W-1:0]  r3_den, r3_num;
    logic signed [DIF_W-1:0] r3_d1x, r3_d1y;

    // stage 4: numerator products
    t_kind                   r4_kind;
    logic signed [OUT_W-1:0] r4_ex, r4_ey;
    logic signed [CO_W-1:0]  r4_ax, r4_ay;
    logic signed [P_W-1:0]   r4_px, r4_py;
    logic [XP_W-1:0]         r4_dmag;
    logic                    r4_dneg;

    // stage 5: magnitudes and divider set-up
    t_div                    r5_d;

    logic signed [XP_W-1:0]  n_o [4];
    logic signed [XP_W-1:0]  n_den, n_num;
    logic [3:0]              n_z, n_n;
    logic                    n_cross;
    t_kind                   n_kind;
    logic signed [OUT_W-1:0] n_ex, n_ey;
    logic [P_W-1:0]          n_magx, n_magy;
    logic [A_W-1:0]          n_ax, n_ay;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_o[k] = XP_W'(r2_p[2*k]) - XP_W'(r2_p[2*k+1]);
            n_z[k] = (n_o[k] == '0);
            n_n[k] = n_o[k][XP_W-1];
        end
        n_den   = XP_W'(r2_p[8]) - XP_W'(r2_p[9]);
        n_num   = XP_W'(r2_p[10]) - XP_W'(r2_p[11]);
        n_cross = ((n_z[0] != n_z[1]) || (n_n[0] != n_n[1])) &&
                  ((n_z[2] != n_z[3]) || (n_n[2] != n_n[3]));
        n_kind  = KIND_NONE;
        n_ex    = '0;
        n_ey    = '0;
        if (n_cross) begin
            if (n_den != '0) begin
                n_kind = KIND_CROSS;
            end
        end else if (n_z[0] && r2_box[0]) begin
            n_kind = KIND_START2;
            n_ex   = to_fixed(r2_s.s2x);
            n_ey   = to_fixed(r2_s.s2y);
        end else if (n_z[1] && r2_box[1]) begin
            n_kind = KIND_END2;
            n_ex   = to_fixed(r2_s.e2x);
            n_ey   = to_fixed(r2_s.e2y);
        end else if (n_z[2] && r2_box[2]) begin
            n_kind = KIND_START1;
            n_ex   = to_fixed(r2_s.s1x);
            n_ey   = to_fixed(r2_s.s1y);
        end else if (n_z[3] && r2_box[3]) begin
            n_kind = KIND_END1;
            n_ex   = to_fixed(r2_s.e1x);
            n_ey   = to_fixed(r2_s.e1y);
        end

        n_magx = r4_px[P_W-1] ? P_W'(-r4_px) : P_W'(r4_px);
        n_magy = r4_py[P_W-1] ? P_W'(-r4_py) : P_W'(r4_py);
        n_ax   = A_W'(n_magx) << FRAC_BITS;
        n_ay   = A_W'(n_magy) << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_s      <= i_seg;
            r1_dif[0] <= DIF_W'(i_seg.e1x) - DIF_W'(i_seg.s1x);   // d1x
            r1_dif[1] <= DIF_W'(i_seg.e1y) - DIF_W'(i_seg.s1y);   // d1y
            r1_dif[2] <= DIF_W'(i_seg.e2x) - DIF_W'(i_seg.s2x);   // d2x
            r1_dif[3] <= DIF_W'(i_seg.e2y) - DIF_W'(i_seg.s2y);   // d2y
            r1_dif[4] <= DIF_W'(i_seg.s2x) - DIF_W'(i_seg.e1x);
            r1_dif[5] <= DIF_W'(i_seg.s2y) - DIF_W'(i_seg.e1y);
            r1_dif[6] <= DIF_W'(i_seg.e2x) - DIF_W'(i_seg.e1x);
            r1_dif[7] <= DIF_W'(i_seg.e2y) - DIF_W'(i_seg.e1y);
            r1_dif[8] <= DIF_W'(i_seg.s1x) - DIF_W'(i_seg.e2x);
            r1_dif[9] <= DIF_W'(i_seg.s1y) - DIF_W'(i_seg.e2y);
            r1_dif[10] <= DIF_W'(i_seg.e1x) - DIF_W'(i_seg.e2x);
            r1_dif[11] <= DIF_W'(i_seg.e1y) - DIF_W'(i_seg.e2y);
            r1_dif[12] <= DIF_W'(i_seg.s1x) - DIF_W'(i_seg.s2x);
            r1_dif[13] <= DIF_W'(i_seg.s1y) - DIF_W'(i_seg.s2y);
            r1_box[0] <= in_box(i_seg.s1x, i_seg.s1y, i_seg.e1x, i_seg.e1y,
                                i_seg.s2x, i_seg.s2y);
            r1_box[1] <= in_box(i_seg.s1x, i_seg.s1y, i_seg.e1x, i_seg.e1y,
                                i_seg.e2x, i_seg.e2y);
            r1_box[2] <= in_box(i_seg.s2x, i_seg.s2y, i_seg.e2x, i_seg.e2y,
                                i_seg.s1x, i_seg.s1y);
            r1_box[3] <= in_box(i_seg.s2x, i_seg.s2y, i_seg.e2x, i_seg.e2y,
                                i_seg.e1x, i_seg.e1y);

            r2_s     <= r1_s;
            r2_box   <= r1_box;
            r2_d1x   <= r1_dif[0];
            r2_d1y   <= r1_dif[1];
            r2_p[0]  <= r1_dif[1] * r1_dif[4];
            r2_p[1]  <= r1_dif[0] * r1_dif[5];
            r2_p[2]  <= r1_dif[1] * r1_dif[6];
            r2_p[3]  <= r1_dif[0] * r1_dif[7];
            r2_p[4]  <= r1_dif[3] * r1_dif[8];
            r2_p[5]  <= r1_dif[2] * r1_dif[9];
            r2_p[6]  <= r1_dif[3] * r1_dif[10];
            r2_p[7]  <= r1_dif[2] * r1_dif[11];
            r2_p[8]  <= r1_dif[0] * r1_dif[3];
            r2_p[9]  <= r1_dif[2] * r1_dif[1];
            r2_p[10] <= r1_dif[2] * r1_dif[13];
            r2_p[11] <= r1_dif[3] * r1_dif[12];

            r3_kind <= n_kind;
            r3_ex   <= n_ex;
            r3_ey   <= n_ey;
            r3_ax   <= r2_s.s1x;
            r3_ay   <= r2_s.s1y;
            r3_den  <= n_den;
            r3_num  <= n_num;
            r3_d1x  <= r2_d1x;
            r3_d1y  <= r2_d1y;

            r4_kind <= r3_kind;
            r4_ex   <= r3_ex;
            r4_ey   <= r3_ey;
            r4_ax   <= r3_ax;
            r4_ay   <= r3_ay;
            r4_px   <= r3_num * r3_d1x;
            r4_py   <= r3_num * r3_d1y;
            r4_dmag <= r3_den[XP_W-1] ? XP_W'(-r3_den) : XP_W'(r3_den);
            r4_dneg <= r3_den[XP_W-1];

            r5_d.kind <= r4_kind;
            r5_d.ex   <= r4_ex;
            r5_d.ey   <= r4_ey;
            r5_d.ax   <= r4_ax;
            r5_d.ay   <= r4_ay;
            r5_d.negx <= r4_px[P_W-1] ^ r4_dneg;
            r5_d.negy <= r4_py[P_W-1] ^ r4_dneg;
            r5_d.dmag <= r4_dmag;
            r5_d.remx <= n_ax[Q_W+XP_W-1:Q_W];
            r5_d.remy <= n_ay[Q_W+XP_W-1:Q_W];
            r5_d.lowx <= n_ax[Q_W-1:0];
            r5_d.lowy <= n_ay[Q_W-1:0];
            r5_d.qx   <= '0;
            r5_d.qy   <= '0;
        end
    end

    assign o_valid = r_v[4];
    assign o_d     = r5_d;

endmodule

`default_nettype wire

@@ rtl/si_div_step.sv @@
`default_nettype none

module si_div_step
    import si_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_ce,
    input  wire logic i_valid,
    input  wire t_div i_d,
    output logic      o_valid,
    output t_div      o_d
);

    logic          r_v;
    t_div          r_d;
    t_div          n_d;
    logic [XP_W:0] n_tx, n_ty, n_dv;

    // one restoring step per axis, one quotient bit
    always_comb begin
        n_d  = i_d;
        n_dv = {1'b0, i_d.dmag};
        n_tx = {i_d.remx, i_d.lowx[Q_W-1]};
        n_ty = {i_d.remy, i_d.lowy[Q_W-1]};
        if (n_tx >= n_dv) begin
            n_d.remx = XP_W'(n_tx - n_dv);
            n_d.qx   = {i_d.qx[Q_W-2:0], 1'b1};
        end else begin
            n_d.remx = n_tx[XP_W-1:0];
            n_d.qx   = {i_d.qx[Q_W-2:0], 1'b0};
        end
        if (n_ty >= n_dv) begin
            n_d.remy = XP_W'(n_ty - n_dv);
            n_d.qy   = {i_d.qy[Q_W-2:0], 1'b1};
        end else begin
            n_d.remy = n_ty[XP_W-1:0];
            n_d.qy   = {i_d.qy[Q_W-2:0], 1'b0};
        end
        n_d.lowx = i_d.lowx << 1;
        n_d.lowy = i_d.lowy << 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_ce) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_v;
    assign o_d     = r_d;

endmodule

`default_nettype wire

@@ rtl/si_round.sv @@
`default_nettype none

module si_round
    import si_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_ce,
    input  wire logic i_valid,
    input  wire t_div i_d,
    output logic      o_valid,
    output t_res      o_res
);

    logic [1:0]             r_v;
    t_kind                  r1_kind;
    logic signed [OUT_W-1:0] r1_ex, r1_ey;
    logic signed [M_W-1:0]  r1_mx, r1_my;
    logic [XP_W-1:0]        r1_rrx, r1_rry, r1_dmag;
    t_res                   r2_res;

    logic signed [M_W-1:0]  n_qx, n_qy, n_mx, n_my, n_fx, n_fy;
    logic                   n_nzx, n_nzy, n_upx, n_upy;
    logic [XP_W:0]          n_2x, n_2y, n_dv;

    always_comb begin
        // floor of the scaled offset, with its remainder
        n_nzx = (i_d.remx != '0);
        n_nzy = (i_d.remy != '0);
        n_qx  = $signed({3'b000, i_d.qx});
        n_qy  = $signed({3'b000, i_d.qy});
        if (i_d.negx) begin
            n_qx = n_nzx ? ~n_qx : -n_qx;
        end
        if (i_d.negy) begin
            n_qy = n_nzy ? ~n_qy : -n_qy;
        end
        n_mx = (M_W'(i_d.ax) <<< FRAC_BITS) + n_qx;
        n_my = (M_W'(i_d.ay) <<< FRAC_BITS) + n_qy;

        // half-way ties go away from zero
        n_dv  = {1'b0, r1_dmag};
        n_2x  = {r1_rrx, 1'b0};
        n_2y  = {r1_rry, 1'b0};
        n_upx = (n_2x > n_dv) || (n_2x == n_dv && !r1_mx[M_W-1]);
        n_upy = (n_2y > n_dv) || (n_2y == n_dv && !r1_my[M_W-1]);
        n_fx  = r1_mx + M_W'(n_upx);
        n_fy  = r1_my + M_W'(n_upy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_kind <= i_d.kind;
            r1_ex   <= i_d.ex;
            r1_ey   <= i_d.ey;
            r1_mx   <= n_mx;
            r1_my   <= n_my;
            r1_rrx  <= (i_d.negx && n_nzx) ? XP_W'(i_d.dmag - i_d.remx) : i_d.remx;
            r1_rry  <= (i_d.negy && n_nzy) ? XP_W'(i_d.dmag - i_d.remy) : i_d.remy;
            r1_dmag <= i_d.dmag;

            r2_res.hit      <= (r1_kind != KIND_NONE);
            r2_res.hit_kind <= r1_kind;
            case (r1_kind)
                KIND_NONE: begin
                    r2_res.cross_x <= '0;
                    r2_res.cross_y <= '0;
                end
                KIND_CROSS: begin
                    r2_res.cross_x <= wrap_out(n_fx);
                    r2_res.cross_y <= wrap_out(n_fy);
                end
                default: begin
                    r2_res.cross_x <= r1_ex;
                    r2_res.cross_y <= r1_ey;
                end
            endcase
        end
    end

    assign o_valid = r_v[1];
    assign o_res   = r2_res;

endmodule

`default_nettype wire

@@ rtl/si_skid.sv @@
`default_nettype none

module si_skid
    import si_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_res i_res,
    output logic      o_ready,
    si_out_if.source  o_res
);

    logic r_out_v, r_skd_v;
    t_res r_out, r_skd;
    logic n_free, n_push;

    assign n_free = !r_out_v || o_res.ready;
    assign n_push = i_valid && !r_skd_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else if (r_skd_v) begin
            if (n_free) begin
                r_out_v <= 1'b1;
                r_skd_v <= 1'b0;
            end
        end else if (n_push) begin
            if (n_free) begin
                r_out_v <= 1'b1;
            end else begin
                r_skd_v <= 1'b1;
            end
        end else if (n_free) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_v) begin
            if (n_free) begin
                r_out <= r_skd;
            end
        end else if (n_push) begin
            if (n_free) begin
                r_out <= i_res;
            end else begin
                r_skd <= i_res;
            end
        end
    end

    assign o_ready        = !r_skd_v;
    assign o_res.valid    = r_out_v;
    assign o_res.hit      = r_out.hit;
    assign o_res.hit_kind = r_out.hit_kind;
    assign o_res.cross_x  = r_out.cross_x;
    assign o_res.cross_y  = r_out.cross_y;

endmodule

`default_nettype wire

@@ rtl/si_chk.sv @@
`default_nettype none

module si_chk
    import si_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              i_ready,
    input wire logic              i_hit,
    input wire logic [2:0]        i_hit_kind,
    input wire logic signed [23:0] i_cross_x,
    input wire logic signed [23:0] i_cross_y
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result offered straight after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_hit_kind) && $stable(i_cross_x)
                               && $stable(i_cross_y))
        else $error("stalled result changed");

    a_hit_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_hit == (i_hit_kind != KIND_NONE)))
        else $error("hit flag disagrees with kind");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_hit_kind <= KIND_END1))
        else $error("unknown hit kind");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_hit |-> (i_cross_x == '0) && (i_cross_y == '0))
        else $error("miss with nonzero point");

endmodule

bind segment_intersection si_chk u_si_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_res.valid),
    .i_ready    (o_res.ready),
    .i_hit      (o_res.hit),
    .i_hit_kind (o_res.hit_kind),
    .i_cross_x  (o_res.cross_x),
    .i_cross_y  (o_res.cross_y)
);

`default_nettype wire
